FILE: rtl/core/vpts_pkg.sv
// ----------------------------------------------------------------------------
// vpts_pkg
// shared constants and types for the vertex project-to-screen core
// ----------------------------------------------------------------------------
package vpts_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned SIZE_W        = 13;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QUOT_W        = 33;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

endpackage

FILE: rtl/core/vpts_front.sv
// ----------------------------------------------------------------------------
// vpts_front
// accepts items, keeps the matrix, forms the x, y and w rows of a point
// ----------------------------------------------------------------------------
module vpts_front #(
  parameter int unsigned FracBits = vpts_pkg::FRAC_BITS_DEF,
  localparam int unsigned HW = 66 - FracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [3:0]                      coef_index_i,
  input  logic signed [31:0]              coef_value_i,
  input  logic signed [31:0]              point_x_i,
  input  logic signed [31:0]              point_y_i,
  input  logic signed [31:0]              point_z_i,
  input  logic [vpts_pkg::QCNT_W-1:0]     q_count_i,
  output logic                            push_o,
  output logic signed [HW-1:0]            push_hx_o,
  output logic signed [HW-1:0]            push_hy_o,
  output logic signed [HW-1:0]            push_w_o
);

  logic signed [31:0] coef_q [16];
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] trans_q [3];
  logic               s1_valid_q;
  logic               accept;
  logic signed [31:0] pt [3];
  logic signed [HW-1:0] sum [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  // leave room in the queue for the item in flight
  assign in_stall_o = ({1'b0, q_count_i} + (vpts_pkg::QCNT_W+1)'(s1_valid_q))
                      >= (vpts_pkg::QCNT_W+1)'(vpts_pkg::QUEUE_DEPTH);
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        coef_q[i] <= (i % 5 == 0) ? (32'sd1 <<< FracBits) : 32'sd0;
      end
    end else if (accept && cmd_i == vpts_pkg::CMD_LOAD) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && cmd_i == vpts_pkg::CMD_POINT;
    end
  end

  // rows 0, 1 and 3 of the matrix; row 2 feeds nothing
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == vpts_pkg::CMD_POINT) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[r][j] <= 64'(coef_q[(r == 2 ? 3 : r) * 4 + j]) * 64'(pt[j]);
        end
        trans_q[r] <= coef_q[(r == 2 ? 3 : r) * 4 + 3];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = HW'(trans_q[r]);
      for (int j = 0; j < 3; j++) begin
        sum[r] = sum[r] + HW'(prod_q[r][j] >>> FracBits);
      end
    end
  end

  assign push_o    = s1_valid_q;
  assign push_hx_o = sum[0];
  assign push_hy_o = sum[1];
  assign push_w_o  = sum[2];

endmodule

FILE: rtl/core/vpts_queue.sv
// ----------------------------------------------------------------------------
// vpts_queue
// small register fifo between the front and the back
// ----------------------------------------------------------------------------
module vpts_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = vpts_pkg::QUEUE_DEPTH,
  localparam int unsigned PW = $clog2(Depth),
  localparam int unsigned CW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic [CW-1:0]    count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: rtl/core/vpts_back.sv
// ----------------------------------------------------------------------------
// vpts_back
// perspective divide and viewport map, one quotient bit per stage
// ----------------------------------------------------------------------------
module vpts_back #(
  parameter int unsigned FracBits = vpts_pkg::FRAC_BITS_DEF,
  localparam int unsigned HW = 66 - FracBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [vpts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [vpts_pkg::SIZE_W-1:0]       cfg_data_i,
  input  logic                              q_valid_i,
  input  logic signed [HW-1:0]              q_hx_i,
  input  logic signed [HW-1:0]              q_hy_i,
  input  logic signed [HW-1:0]              q_w_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                screen_x_o,
  output logic signed [31:0]                screen_y_o,
  output logic                              w_zero_o
);

  localparam int unsigned QW  = vpts_pkg::QUOT_W;
  localparam int unsigned DW  = HW + 1;
  localparam int unsigned MW  = HW + 1 + vpts_pkg::SIZE_W;
  localparam int unsigned NW  = MW + FracBits;
  localparam int unsigned CMW = (NW > DW + QW) ? NW : DW + QW;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [DW-1:0] den;
    logic          neg;
    logic          ovf;
  } div_t;

  logic [vpts_pkg::SIZE_W-1:0] width_q, height_q;
  logic adv;

  // b0: magnitudes and signs
  logic          v0_q, wz0_q, negx0_q, negy0_q;
  logic [DW-1:0] magx0_q, magy0_q, den0_q;
  // b1: scaled by viewport size
  logic          v1_q, wz1_q, negx1_q, negy1_q;
  logic [MW-1:0] px1_q, py1_q;
  logic [DW-1:0] den1_q;

  logic signed [HW:0] nx, ny, ww;
  logic [NW-1:0]      numx, numy;

  div_t dx_q [QW+1];
  div_t dy_q [QW+1];
  logic vs_q [QW+1];
  logic wzs_q [QW+1];

  logic               out_valid_q, wz_out_q;
  logic signed [31:0] sx_q, sy_q;

  function automatic div_t div_step(div_t a);
    logic [DW:0] t;
    div_t        r;
    t = {a.rem, a.low[QW-1]};
    r = a;
    if (t >= {1'b0, a.den}) begin
      r.rem = DW'(t - {1'b0, a.den});
      r.low = {a.low[QW-2:0], 1'b1};
    end else begin
      r.rem = t[DW-1:0];
      r.low = {a.low[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_t div_init(logic [NW-1:0] num, logic [DW-1:0] den, logic neg);
    div_t r;
    r.rem = DW'(num >> QW);
    r.low = num[QW-1:0];
    r.den = den;
    r.neg = neg;
    // quotient of 2^33 or more saturates, and so does a zero divisor
    r.ovf = CMW'(num) >= (CMW'(den) << QW);
    return r;
  endfunction

  function automatic logic [31:0] sat_map(div_t a);
    logic [31:0] r;
    if (a.ovf) begin
      r = a.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (!a.neg) begin
      r = (a.low > QW'(32'h7fff_ffff)) ? 32'h7fff_ffff : a.low[31:0];
    end else begin
      r = (a.low > QW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-a.low[31:0]);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= vpts_pkg::WIDTH_RST;
      height_q <= vpts_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == vpts_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == vpts_pkg::CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // the whole pipe holds while a result waits
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_valid_i;

  assign ww = (HW+1)'(q_w_i);
  assign nx = (HW+1)'(q_hx_i) + ww;
  assign ny = (HW+1)'(q_hy_i) + ww;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        vs_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v0_q        <= q_valid_i;
      v1_q        <= v0_q;
      vs_q[0]     <= v1_q;
      for (int k = 1; k <= QW; k++) begin
        vs_q[k] <= vs_q[k-1];
      end
      out_valid_q <= vs_q[QW];
    end
  end

  assign numx = {px1_q, FracBits'(0)};
  assign numy = {py1_q, FracBits'(0)};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wz0_q   <= q_w_i == '0;
      negx0_q <= nx[HW] ^ ww[HW];
      negy0_q <= ny[HW] ^ ww[HW];
      magx0_q <= nx[HW] ? DW'(-nx) : DW'(nx);
      magy0_q <= ny[HW] ? DW'(-ny) : DW'(ny);
      den0_q  <= ww[HW] ? DW'(-ww) << 1 : DW'(ww) << 1;

      wz1_q   <= wz0_q;
      negx1_q <= negx0_q;
      negy1_q <= negy0_q;
      den1_q  <= den0_q;
      px1_q   <= MW'(magx0_q) * MW'(width_q);
      py1_q   <= MW'(magy0_q) * MW'(height_q);

      dx_q[0]  <= div_init(numx, den1_q, negx1_q);
      dy_q[0]  <= div_init(numy, den1_q, negy1_q);
      wzs_q[0] <= wz1_q;
      for (int k = 1; k <= QW; k++) begin
        dx_q[k]  <= div_step(dx_q[k-1]);
        dy_q[k]  <= div_step(dy_q[k-1]);
        wzs_q[k] <= wzs_q[k-1];
      end

      wz_out_q <= wzs_q[QW];
      sx_q     <= wzs_q[QW] ? 32'sd0 : sat_map(dx_q[QW]);
      sy_q     <= wzs_q[QW] ? 32'sd0 : sat_map(dy_q[QW]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign w_zero_o    = wz_out_q;

endmodule

FILE: rtl/core/vertex_project_to_screen_core.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen_core
// 4x4 matrix transform, perspective divide and viewport map of points
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | cmd, coef_index, coef_value, point_x/y/z
//  out     | out_valid_o/out_stall_i | screen_x, screen_y, w_zero
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; a point result
// passes the multiply, queue, two scaling stages, divide setup, 33 one-bit divide
// stages and the output register, in that order.
// reset loads the identity matrix and a 640 by 480 viewport.
// a stalled output holds the back pipe; the front keeps taking items until
// the four-entry queue fills.
module vertex_project_to_screen_core #(
  parameter int unsigned FracBits = vpts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [3:0]                     coef_index_i,
  input  logic signed [31:0]             coef_value_i,
  input  logic signed [31:0]             point_x_i,
  input  logic signed [31:0]             point_y_i,
  input  logic signed [31:0]             point_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             screen_x_o,
  output logic signed [31:0]             screen_y_o,
  output logic                           w_zero_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vpts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vpts_pkg::SIZE_W-1:0]    cfg_data_i
);

  localparam int unsigned HW = 66 - FracBits;

  logic                        push, pop, q_valid;
  logic signed [HW-1:0]        push_hx, push_hy, push_w;
  logic [3*HW-1:0]             q_data;
  logic [vpts_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  vpts_front #(.FracBits(FracBits)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_hx_o    (push_hx),
    .push_hy_o    (push_hy),
    .push_w_o     (push_w)
  );

  vpts_queue #(.Width(3 * HW), .Depth(vpts_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_hx, push_hy, push_w}),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  vpts_back #(.FracBits(FracBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_hx_i      (q_data[3*HW-1:2*HW]),
    .q_hy_i      (q_data[2*HW-1:HW]),
    .q_w_i       (q_data[HW-1:0]),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .w_zero_o    (w_zero_o)
  );

endmodule
